// ===== rtl/efd_pkg.sv =====
// ----------------------------------------------------------------------------
// Escaped frame deframer package
// Byte codes, phase and status codes, and the types used by the deframer.
// ----------------------------------------------------------------------------
package efd_pkg;

    // Wire bytes of the escaped framing.
    localparam logic [7:0] FLAG_BYTE = 8'h5a;
    localparam logic [7:0] ESC_BYTE  = 8'h5b;
    localparam logic [7:0] ESC_FLAG  = 8'h01;
    localparam logic [7:0] ESC_ESC   = 8'h02;

    // Smallest legal frame, both flags included.
    localparam logic [15:0] MIN_FRAME = 16'd5;
    localparam logic [15:0] COUNT_MAX = 16'hffff;

    // Frame phase codes.
    localparam logic [1:0] PH_HUNT   = 2'd0;
    localparam logic [1:0] PH_DECODE = 2'd1;
    localparam logic [1:0] PH_DONE   = 2'd2;

    // Status codes carried by a frame_done item.
    localparam logic [2:0] ST_OK           = 3'd0;
    localparam logic [2:0] ST_TOO_SHORT    = 3'd1;
    localparam logic [2:0] ST_LEN_MISMATCH = 3'd2;
    localparam logic [2:0] ST_CSUM_BAD     = 3'd3;
    localparam logic [2:0] ST_UNTERMINATED = 3'd4;
    localparam logic [2:0] ST_NO_START     = 3'd5;

    // Decoder state carried from one item to the next.
    typedef struct packed {
        logic [1:0]  phase;
        logic        escape_pending;
        logic [7:0]  held_byte;
        logic [15:0] decoded_count;
        logic [7:0]  running_sum;
        logic [15:0] declared_length;
    } state_t;

    localparam state_t STATE_RESET = '{
        phase:           PH_HUNT,
        escape_pending:  1'b0,
        held_byte:       8'h00,
        decoded_count:   16'h0000,
        running_sum:     8'h00,
        declared_length: 16'h0000
    };

    // One result item.
    typedef struct packed {
        logic [7:0] payload_byte;
        logic       frame_done;
        logic [2:0] frame_status;
    } result_t;

    // Outcome of appending one decoded byte to the frame.
    typedef struct packed {
        state_t     st;
        logic       emit;
        logic [7:0] value;
    } push_t;

endpackage

// ===== rtl/efd_if.sv =====
// ----------------------------------------------------------------------------
// Escaped frame deframer channels
// Valid/ready interfaces for the raw byte input and the result output.
// ----------------------------------------------------------------------------
interface efd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] raw_byte;
    logic       report_end;

    modport source (output valid, output raw_byte, output report_end, input ready);
    modport sink   (input valid, input raw_byte, input report_end, output ready);
endinterface

interface efd_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] payload_byte;
    logic       frame_done;
    logic [2:0] frame_status;

    modport source (output valid, output payload_byte, output frame_done,
                    output frame_status, input ready);
    modport sink   (input valid, input payload_byte, input frame_done,
                    input frame_status, output ready);
endinterface

// ===== rtl/escaped_frame_deframer_unit.sv =====
// ----------------------------------------------------------------------------
// Escaped frame deframer
// Hunts for the start flag, unescapes the frame, streams payload bytes and
// gives one status item per frame or per report.
// ----------------------------------------------------------------------------
//
//  Channel | Dir | Handshake   | Payload
//  --------+-----+-------------+----------------------------------------------
//  rx      | in  | valid/ready | raw_byte[7:0], report_end
//  tx      | out | valid/ready | payload_byte[7:0], frame_done, frame_status[2:0]
//
// One input item is taken per cycle while rx.ready is high; an item yields zero,
// one or two results. A result passes the input register, then the two-entry
// result buffer, before it leaves. An item whose results do not fit in the
// buffer is held in the input register until the buffer has room.
// rst_n clears the decoder state and empties the input register and the result buffer.
// rx.ready drops only while the result buffer cannot take the pending results.
module escaped_frame_deframer_unit (
    input  logic       clk,
    input  logic       rst_n,
    efd_in_if.sink     rx,
    efd_out_if.source  tx
);

    // Input register.
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_last_reg;

    // Decoder state.
    efd_pkg::state_t state_reg;
    efd_pkg::state_t state_next;

    // Result buffer, entry 0 drives the output.
    efd_pkg::result_t slot_reg  [2];
    efd_pkg::result_t slot_next [2];
    logic [1:0]       buf_cnt_reg;
    logic [1:0]       buf_cnt_next;

    // Per-item decode results.
    efd_pkg::state_t  st_work;
    efd_pkg::push_t   push_a;
    efd_pkg::push_t   push_b;
    efd_pkg::result_t res [2];
    logic [1:0]       nres;
    logic             normal;

    logic       rx_accept;
    logic       tx_pop;
    logic [1:0] space;
    logic       advance;
    logic [1:0] rem_cnt;
    logic       wr_idx [2];

    // Append one decoded byte; the byte before it is emitted once the
    // length field and the first held byte are past.
    function automatic efd_pkg::push_t push_byte(efd_pkg::state_t s, logic [7:0] v);
        efd_pkg::push_t p;
        p       = '0;
        p.st    = s;
        p.emit  = 1'b0;
        p.value = s.held_byte;
        if (s.decoded_count == 16'd1)
        begin
            p.st.declared_length[15:8] = v;
            p.st.running_sum           = s.running_sum + v;
        end
        else if (s.decoded_count == 16'd2)
        begin
            p.st.declared_length[7:0] = v;
            p.st.running_sum          = s.running_sum + v;
        end
        else if (s.decoded_count == 16'd3)
        begin
            p.st.held_byte = v;
        end
        else if (s.decoded_count >= 16'd4)
        begin
            p.emit         = 1'b1;
            p.st.running_sum = s.running_sum + s.held_byte;
            p.st.held_byte = v;
        end
        if (s.decoded_count != efd_pkg::COUNT_MAX)
        begin
            p.st.decoded_count = s.decoded_count + 16'd1;
        end
        return p;
    endfunction

    // Status at the closing flag, checks in priority order.
    function automatic logic [2:0] close_status(efd_pkg::state_t s);
        logic [2:0] r;
        if (s.decoded_count < efd_pkg::MIN_FRAME - 16'd1)
        begin
            r = efd_pkg::ST_TOO_SHORT;
        end
        else if (s.decoded_count == efd_pkg::COUNT_MAX ||
                 s.declared_length != s.decoded_count + 16'd1)
        begin
            r = efd_pkg::ST_LEN_MISMATCH;
        end
        else if (s.running_sum != s.held_byte)
        begin
            r = efd_pkg::ST_CSUM_BAD;
        end
        else
        begin
            r = efd_pkg::ST_OK;
        end
        return r;
    endfunction

    // Decode the registered item against the current state.
    always_comb
    begin
        st_work = state_reg;
        nres    = 2'd0;
        res[0]  = '0;
        res[1]  = '0;
        normal  = 1'b1;
        push_a  = push_byte(state_reg, efd_pkg::ESC_BYTE);
        push_b  = '0;

        case (state_reg.phase)
            efd_pkg::PH_HUNT:
            begin
                if (in_byte_reg == efd_pkg::FLAG_BYTE)
                begin
                    st_work               = efd_pkg::STATE_RESET;
                    st_work.phase         = efd_pkg::PH_DECODE;
                    st_work.decoded_count = 16'd1;
                end
            end
            efd_pkg::PH_DECODE:
            begin
                // A pending escape resolves first.
                if (state_reg.escape_pending)
                begin
                    if (in_byte_reg == efd_pkg::ESC_FLAG)
                    begin
                        push_a = push_byte(state_reg, efd_pkg::FLAG_BYTE);
                        normal = 1'b0;
                    end
                    else if (in_byte_reg == efd_pkg::ESC_ESC)
                    begin
                        normal = 1'b0;
                    end
                    st_work                = push_a.st;
                    st_work.escape_pending = 1'b0;
                    if (push_a.emit)
                    begin
                        res[0] = '{payload_byte: push_a.value, frame_done: 1'b0,
                                   frame_status: efd_pkg::ST_OK};
                        nres   = 2'd1;
                    end
                end

                // Then the byte itself, unless it completed an escape.
                if (normal)
                begin
                    push_b = push_byte(st_work, in_byte_reg);
                    if (in_byte_reg == efd_pkg::FLAG_BYTE)
                    begin
                        res[nres[0]] = '{payload_byte: 8'h00, frame_done: 1'b1,
                                         frame_status: close_status(st_work)};
                        nres         = nres + 2'd1;
                        st_work.phase = efd_pkg::PH_DONE;
                    end
                    else if (in_byte_reg == efd_pkg::ESC_BYTE)
                    begin
                        st_work.escape_pending = 1'b1;
                    end
                    else
                    begin
                        st_work = push_b.st;
                        if (push_b.emit)
                        begin
                            res[nres[0]] = '{payload_byte: push_b.value, frame_done: 1'b0,
                                             frame_status: efd_pkg::ST_OK};
                            nres         = nres + 2'd1;
                        end
                    end
                end
            end
            default:
            begin
                // Frame closed: ignore bytes until the report ends.
            end
        endcase

        // Report end replaces results unless a frame closed; restarts the hunt.
        if (in_last_reg)
        begin
            if (st_work.phase == efd_pkg::PH_DECODE)
            begin
                res[0] = '{payload_byte: 8'h00, frame_done: 1'b1,
                           frame_status: efd_pkg::ST_UNTERMINATED};
                nres   = 2'd1;
            end
            else if (st_work.phase == efd_pkg::PH_HUNT)
            begin
                res[0] = '{payload_byte: 8'h00, frame_done: 1'b1,
                           frame_status: efd_pkg::ST_NO_START};
                nres   = 2'd1;
            end
            st_work = efd_pkg::STATE_RESET;
        end
    end

    // Handshakes and buffer space.
    assign tx_pop    = (buf_cnt_reg != 2'd0) && tx.ready;
    assign space     = 2'd2 - buf_cnt_reg + {1'b0, tx_pop};
    assign advance   = in_valid_reg && (nres <= space);
    assign rx.ready  = !in_valid_reg || advance;
    assign rx_accept = rx.valid && rx.ready;
    assign rem_cnt   = buf_cnt_reg - {1'b0, tx_pop};

    // Next buffer contents: shift on pop, then append new results.
    // A write only happens while at most one entry remains, so the low bit
    // of the fill level picks the entry.
    always_comb
    begin
        slot_next[0] = tx_pop ? slot_reg[1] : slot_reg[0];
        slot_next[1] = slot_reg[1];
        for (int i = 0; i < 2; i++)
        begin
            wr_idx[i] = rem_cnt[0] ^ 1'(i);
            if (advance && (2'(i) < nres))
            begin
                slot_next[wr_idx[i]] = res[i];
            end
        end
        buf_cnt_next = rem_cnt + (advance ? nres : 2'd0);
        state_next   = advance ? st_work : state_reg;
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            buf_cnt_reg  <= 2'd0;
            state_reg    <= efd_pkg::STATE_RESET;
        end
        else
        begin
            if (rx_accept)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end
            buf_cnt_reg <= buf_cnt_next;
            state_reg   <= state_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (rx_accept)
        begin
            in_byte_reg <= rx.raw_byte;
            in_last_reg <= rx.report_end;
        end
        slot_reg[0] <= slot_next[0];
        slot_reg[1] <= slot_next[1];
    end

    // Output.
    assign tx.valid        = (buf_cnt_reg != 2'd0);
    assign tx.payload_byte = slot_reg[0].payload_byte;
    assign tx.frame_done   = slot_reg[0].frame_done;
    assign tx.frame_status = slot_reg[0].frame_status;

    // The result buffer never holds more than two items.
    a_buf_bound: assert property (@(posedge clk) disable iff (!rst_n)
        buf_cnt_reg <= 2'd2)
        else $error("result buffer overfilled");

    // An escape can only be pending inside a frame.
    a_esc_phase: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.escape_pending |-> state_reg.phase == efd_pkg::PH_DECODE)
        else $error("escape pending outside a frame");

    // A report end returns the decoder to the hunt with cleared counters.
    a_end_reset: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && in_last_reg) |=>
            (state_reg.phase == efd_pkg::PH_HUNT && state_reg.decoded_count == 16'd0))
        else $error("report end did not reset the decoder");

    // A shown result never mixes payload and status fields.
    a_result_form: assert property (@(posedge clk) disable iff (!rst_n)
        (buf_cnt_reg != 2'd0) |->
            (slot_reg[0].frame_done ? slot_reg[0].payload_byte == 8'h00
                                    : slot_reg[0].frame_status == efd_pkg::ST_OK))
        else $error("malformed result item");

    // A waiting input item is taken whenever the result buffer is empty.
    a_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && buf_cnt_reg == 2'd0) |-> advance)
        else $error("input stalled with an empty result buffer");

endmodule
